// File: rtl/mi3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_pkg: shared definitions for the 3x3 matrix inverse
// Cofactor operand table, sideband bit positions and divider status flags.
// ----------------------------------------------------------------------------
package mi3_pkg;

	// Row-major operand indices for each cofactor, evaluated as p*q - s*t.
	localparam int unsigned COF_IDX [9][4] = '{
		'{4, 8, 7, 5}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
		'{5, 6, 3, 8}, '{0, 8, 2, 6}, '{3, 2, 0, 5},
		'{3, 7, 6, 4}, '{6, 1, 0, 7}, '{0, 4, 3, 1}
	};

	// Cofactors used by the first-row expansion of the determinant.
	localparam int unsigned DET_COF [3] = '{0, 3, 6};

	// Bit positions in the result sideband.
	localparam int unsigned USER_SINGULAR  = 0;
	localparam int unsigned USER_SATURATED = 1;
	localparam int unsigned USER_WIDTH     = 2;

	typedef struct packed {
		logic sat;
		logic dzero;
	} mi3_flags_t;

endpackage

// File: rtl/mi3_cof.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_cof: adjugate cofactor stages
// Stage 1 forms the eighteen element products, stage 2 their differences.
// ----------------------------------------------------------------------------
module mi3_cof #(
	parameter int W = 32
) (
	input  logic                  clk,
	input  logic [1:0]            load,
	input  logic signed [W-1:0]   a [9],
	output logic signed [2*W:0]   cof_s2 [9],
	output logic signed [W-1:0]   a0_s2 [3]
);

	logic signed [2*W-1:0] pp_s1 [9];
	logic signed [2*W-1:0] pq_s1 [9];
	logic signed [W-1:0]   a0_s1 [3];

	for (genvar k = 0; k < 9; k++) begin : g_cof
		always_ff @(posedge clk) begin
			if (load[0]) begin
				pp_s1[k] <= a[mi3_pkg::COF_IDX[k][0]] * a[mi3_pkg::COF_IDX[k][1]];
				pq_s1[k] <= a[mi3_pkg::COF_IDX[k][2]] * a[mi3_pkg::COF_IDX[k][3]];
			end
			if (load[1]) begin
				cof_s2[k] <= (2*W+1)'(pp_s1[k]) - (2*W+1)'(pq_s1[k]);
			end
		end
	end

	for (genvar j = 0; j < 3; j++) begin : g_row
		always_ff @(posedge clk) begin
			if (load[0]) begin
				a0_s1[j] <= a[j];
			end
			if (load[1]) begin
				a0_s2[j] <= a0_s1[j];
			end
		end
	end

endmodule

// File: rtl/mi3_det.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_det: determinant stages
// First-row expansion with each wide cofactor split into two halves, so no
// multiplier exceeds one element by one half cofactor.
// ----------------------------------------------------------------------------
module mi3_det #(
	parameter int W = 32
) (
	input  logic                    clk,
	input  logic [2:0]              load,
	input  logic signed [2*W:0]     cof_in [9],
	input  logic signed [W-1:0]     a0_in [3],
	output logic signed [2*W:0]     cof_s5 [9],
	output logic signed [3*W+1:0]   det_s5
);

	localparam int DTW = 3*W + 2;

	logic signed [2*W:0]   pl_s3 [3];
	logic signed [2*W:0]   ph_s3 [3];
	logic signed [DTW-1:0] term_s4 [3];
	logic signed [2*W:0]   cof_s3 [9];
	logic signed [2*W:0]   cof_s4 [9];

	for (genvar j = 0; j < 3; j++) begin : g_term
		logic signed [DTW-1:0] hi_ext;
		logic signed [DTW-1:0] lo_ext;

		assign hi_ext = DTW'(ph_s3[j]);
		assign lo_ext = DTW'(pl_s3[j]);

		always_ff @(posedge clk) begin
			if (load[0]) begin
				pl_s3[j] <= a0_in[j] *
					$signed({1'b0, cof_in[mi3_pkg::DET_COF[j]][W-1:0]});
				ph_s3[j] <= a0_in[j] * $signed(cof_in[mi3_pkg::DET_COF[j]][2*W:W]);
			end
			if (load[1]) begin
				term_s4[j] <= (hi_ext <<< W) + lo_ext;
			end
		end
	end

	for (genvar k = 0; k < 9; k++) begin : g_carry
		always_ff @(posedge clk) begin
			if (load[0]) begin
				cof_s3[k] <= cof_in[k];
			end
			if (load[1]) begin
				cof_s4[k] <= cof_s3[k];
			end
			if (load[2]) begin
				cof_s5[k] <= cof_s4[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load[2]) begin
			det_s5 <= term_s4[0] + term_s4[1] + term_s4[2];
		end
	end

endmodule

// File: rtl/mi3_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_div: pipelined restoring divider for one inverse element
// Prepares magnitudes, resolves one quotient bit per stage after an overflow
// test, adds a rounding bit, then rounds, saturates and restores the sign.
// ----------------------------------------------------------------------------
module mi3_div #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                   clk,
	input  logic [W+3:0]           load,
	input  logic signed [2*W:0]    cof,
	input  logic signed [3*W+1:0]  det,
	output logic [W-1:0]           quo_q,
	output mi3_pkg::mi3_flags_t    flags_q
);

	localparam int CFW = 2*W + 1;
	localparam int DTW = 3*W + 2;
	localparam int NW  = CFW + 2*F;
	localparam int SW  = DTW + W;
	localparam int CW  = ((NW > SW) ? NW : SW) + 1;

	logic [CW-1:0]  rem_s  [W+2];
	logic [DTW-1:0] dmag_s [W+2];
	logic [W+1:0]   qb_s   [W+3];
	logic           neg_s  [W+3];
	logic           dz_s   [W+3];

	logic [CFW-1:0] cabs;
	logic [DTW-1:0] dabs;

	assign cabs = cof[CFW-1] ? CFW'(-cof) : CFW'(cof);
	assign dabs = det[DTW-1] ? DTW'(-det) : DTW'(det);

	always_ff @(posedge clk) begin
		if (load[0]) begin
			rem_s[0]  <= CW'(cabs) << (2*F);
			dmag_s[0] <= dabs;
			qb_s[0]   <= '0;
			neg_s[0]  <= cof[CFW-1] ^ det[DTW-1];
			dz_s[0]   <= (det == '0);
		end
	end

	// Step j tests the remainder against the divisor shifted by W-j; the first
	// step flags a quotient of 2^W or more.
	for (genvar j = 0; j <= W; j++) begin : g_step
		logic [CW-1:0] dsh;
		logic          ge;

		assign dsh = CW'(dmag_s[j]) << (W - j);
		assign ge  = (rem_s[j] >= dsh);

		always_ff @(posedge clk) begin
			if (load[j+1]) begin
				rem_s[j+1]  <= ge ? (rem_s[j] - dsh) : rem_s[j];
				dmag_s[j+1] <= dmag_s[j];
				qb_s[j+1]   <= qb_s[j] | ((W+2)'(ge) << (W + 1 - j));
				neg_s[j+1]  <= neg_s[j];
				dz_s[j+1]   <= dz_s[j];
			end
		end
	end

	logic rbit;
	assign rbit = ({rem_s[W+1], 1'b0} >= (CW+1)'(dmag_s[W+1]));

	always_ff @(posedge clk) begin
		if (load[W+2]) begin
			qb_s[W+2]  <= qb_s[W+1] | (W+2)'(rbit);
			neg_s[W+2] <= neg_s[W+1];
			dz_s[W+2]  <= dz_s[W+1];
		end
	end

	logic [W:0] qr;
	logic [W:0] lim;
	logic       sat;
	logic [W:0] mag;
	logic [W:0] sgn;

	always_comb begin
		qr  = {1'b0, qb_s[W+2][W:1]} + (W+1)'(qb_s[W+2][0]);
		lim = ((W+1)'(1) << (W - 1)) - (W+1)'(!neg_s[W+2]);
		sat = qb_s[W+2][W+1] || (qr > lim);
		mag = sat ? lim : qr;
		sgn = neg_s[W+2] ? -mag : mag;
	end

	always_ff @(posedge clk) begin
		if (load[W+3]) begin
			quo_q         <= dz_s[W+2] ? '0 : sgn[W-1:0];
			flags_q.sat   <= sat && !dz_s[W+2];
			flags_q.dzero <= dz_s[W+2];
		end
	end

endmodule

// File: rtl/matrix_inverse_3x3.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_inverse_3x3: pipelined 3x3 inverse by adjugate and determinant
// One signed fixed-point matrix in, its rounded and saturated inverse out.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one matrix per transaction, nine elements packed
//   row-major in s_tdata. The master channel returns the nine inverse
//   elements in m_tdata with the singular and saturated flags in m_tuser.
//   Throughput is one matrix per cycle while the receiver keeps up. The
//   pipeline has two cofactor stages, three determinant stages, and per
//   element a divider of DATA_WIDTH + 4 stages that settles one quotient
//   bit per stage. The divider depth sets the latency.
//   Every stage holds a valid bit and loads when it is empty or its
//   successor moves, so bubbles close up and a stalled receiver backs the
//   pipeline up one stage at a time; s_tready drops only once every stage
//   is occupied. Reset clears the valid bits; no state outlives an item.
//   A zero determinant gives all-zero elements with singular set.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3 #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// a00, a01, a02, a10, a11, a12, a20, a21, a22, zero padding
	input  logic [((9*DATA_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// b00, b01, b02, b10, b11, b12, b20, b21, b22, zero padding
	output logic [((9*DATA_WIDTH+7)/8)*8-1:0] m_tdata,
	// singular, saturated
	output logic [mi3_pkg::USER_WIDTH-1:0] m_tuser
);

	localparam int W   = DATA_WIDTH;
	localparam int NS  = W + 9;
	localparam int DTW = 3*W + 2;

	logic [NS-1:0] vld_q;
	logic [NS:0]   load;

	assign load[NS] = m_tready;
	for (genvar k = 0; k < NS; k++) begin : g_flow
		assign load[k] = !vld_q[k] || load[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < NS; k++) begin
				if (load[k]) begin
					vld_q[k] <= (k == 0) ? s_tvalid : vld_q[(k == 0) ? 0 : k-1];
				end
			end
		end
	end

	assign s_tready = load[0];
	assign m_tvalid = vld_q[NS-1];

	logic signed [W-1:0]   a [9];
	logic signed [2*W:0]   cof_s2 [9];
	logic signed [W-1:0]   a0_s2 [3];
	logic signed [2*W:0]   cof_s5 [9];
	logic signed [DTW-1:0] det_s5;
	logic [W-1:0]          b [9];
	mi3_pkg::mi3_flags_t   flg [9];
	logic [8:0]            dz_all;
	logic [8:0]            sat_all;

	for (genvar k = 0; k < 9; k++) begin : g_unpack
		assign a[k] = $signed(s_tdata[k*W +: W]);
	end

	mi3_cof #(.W(W)) u_cof (
		.clk    (clk),
		.load   (load[1:0]),
		.a      (a),
		.cof_s2 (cof_s2),
		.a0_s2  (a0_s2)
	);

	mi3_det #(.W(W)) u_det (
		.clk    (clk),
		.load   (load[4:2]),
		.cof_in (cof_s2),
		.a0_in  (a0_s2),
		.cof_s5 (cof_s5),
		.det_s5 (det_s5)
	);

	for (genvar k = 0; k < 9; k++) begin : g_div
		mi3_div #(.W(W), .F(FRAC_BITS)) u_div (
			.clk     (clk),
			.load    (load[NS-1:5]),
			.cof     (cof_s5[k]),
			.det     (det_s5),
			.quo_q   (b[k]),
			.flags_q (flg[k])
		);
		assign dz_all[k]  = flg[k].dzero;
		assign sat_all[k] = flg[k].sat;
	end

	always_comb begin
		m_tdata = '0;
		for (int k = 0; k < 9; k++) begin
			m_tdata[k*W +: W] = b[k];
		end
	end

	assign m_tuser[mi3_pkg::USER_SINGULAR]  = &dz_all;
	assign m_tuser[mi3_pkg::USER_SATURATED] = |sat_all;

	// An empty output stage means every stage can load.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled while the output stage is empty");

	// A consumed output lets the whole chain advance.
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled while the receiver accepts");

	// A singular result carries no saturation and zero elements.
	a_singular_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[mi3_pkg::USER_SINGULAR]) |->
			(!m_tuser[mi3_pkg::USER_SATURATED] && (m_tdata == '0)))
		else $error("singular result with nonzero data or saturation");

endmodule

// File: tb/matrix_inverse_3x3_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_tb: self-checking bench for the 3x3 matrix inverse
// Sends matrices over the slave stream and predicts each inverse exactly with
// wide integers: cofactors, determinant, rounded division and saturation.
// Every result on the master stream is compared with the oldest prediction.
// Both streams idle at random, with some stretches that run at full rate.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3_tb;

	localparam int DW = 32;
	localparam int FB = 16;
	localparam int TDW = ((9*DW+7)/8)*8;
	localparam logic [DW-1:0] ONE = 32'h0001_0000;
	localparam logic [DW-1:0] MAXV = 32'h7fff_ffff;
	localparam logic [DW-1:0] MINV = 32'h8000_0000;

	typedef logic [DW-1:0] mat_t [9];
	typedef logic signed [199:0] wide_t;

	typedef struct {
		logic [DW-1:0] b [9];
		logic          singular;
		logic          saturated;
	} inverse_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [TDW-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [TDW-1:0] m_tdata;
	logic [mi3_pkg::USER_WIDTH-1:0] m_tuser;

	inverse_t pending_inverses [$];
	int errors = 0;
	int matrices_sent = 0;
	int inverses_checked = 0;
	int singular_seen = 0;
	int saturated_seen = 0;
	bit full_rate = 0;

	matrix_inverse_3x3 dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic int pause_len();
		if (full_rate)
			return 0;
		return $urandom_range(0, 18);
	endfunction

	// Exact inverse: adjugate over determinant, rounded half away from zero.
	function automatic inverse_t invert(mat_t a);
		inverse_t r;
		wide_t e [9];
		wide_t cof [9];
		wide_t det, num, dmag, nmag, q, rem;
		wide_t lim_pos, lim_neg;
		bit qneg;
		for (int k = 0; k < 9; k++)
			e[k] = wide_t'($signed(a[k]));
		for (int k = 0; k < 9; k++)
			cof[k] = e[mi3_pkg::COF_IDX[k][0]] * e[mi3_pkg::COF_IDX[k][1]]
				- e[mi3_pkg::COF_IDX[k][2]] * e[mi3_pkg::COF_IDX[k][3]];
		det = e[0] * cof[0] + e[1] * cof[3] + e[2] * cof[6];
		r.singular = (det == 0);
		r.saturated = 0;
		lim_pos = (wide_t'(1) <<< (DW-1)) - 1;
		lim_neg = wide_t'(1) <<< (DW-1);
		dmag = (det < 0) ? -det : det;
		for (int k = 0; k < 9; k++) begin
			r.b[k] = '0;
			if (!r.singular) begin
				num = cof[k] <<< (2*FB);
				nmag = (num < 0) ? -num : num;
				q = nmag / dmag;
				rem = nmag % dmag;
				if (2*rem >= dmag)
					q = q + 1;
				qneg = (cof[k] < 0) != (det < 0);
				if (!qneg && q > lim_pos) begin
					q = lim_pos;
					r.saturated = 1;
				end else if (qneg && q > lim_neg) begin
					q = lim_neg;
					r.saturated = 1;
				end
				r.b[k] = qneg ? DW'(-q) : DW'(q);
			end
		end
		return r;
	endfunction

	// Sends one matrix; s_tvalid stays high into the next call when it has no pause.
	task automatic send_matrix(mat_t a);
		int gap;
		gap = pause_len();
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		for (int k = 0; k < 9; k++)
			s_tdata[k*DW +: DW] <= a[k];
		do @(posedge clk); while (!s_tready);
		pending_inverses.push_back(invert(a));
		matrices_sent++;
	endtask

	function automatic mat_t diag(logic [DW-1:0] d0, logic [DW-1:0] d1, logic [DW-1:0] d2);
		mat_t a;
		foreach (a[k]) a[k] = '0;
		a[0] = d0; a[4] = d1; a[8] = d2;
		return a;
	endfunction

	function automatic mat_t fill(logic [DW-1:0] v);
		mat_t a;
		foreach (a[k]) a[k] = v;
		return a;
	endfunction

	// Element of about +-8.0 with random fractional bits.
	function automatic logic [DW-1:0] modest();
		return DW'($signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
	endfunction

	task automatic test_directed();
		mat_t a;
		send_matrix(diag(ONE, ONE, ONE));
		send_matrix(fill('0));
		send_matrix(fill(MAXV));
		send_matrix(fill(MINV));
		send_matrix(diag(MAXV, MAXV, MAXV));
		send_matrix(diag(MINV, MINV, MINV));
		send_matrix(diag(32'd1, 32'd1, 32'd1));
		send_matrix(diag(32'd2, 32'd2, 32'd2));
		send_matrix(diag(-32'd2, -32'd2, -32'd2));
		send_matrix(diag(-32'd1, ONE, MAXV));
		send_matrix(diag(32'h0003_0000, 32'h0002_0000, -32'h0003_0000));
		send_matrix(diag(32'h0000_8000, 32'h0006_0000, 32'h0007_0000));
		a = diag(ONE, ONE, ONE);
		a[1] = MINV; a[5] = MAXV; a[6] = 32'h0002_8000;
		send_matrix(a);
		a = '{ONE, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'h0005_0000,
			32'h0006_0000, 32'h0007_0000, 32'h0008_0000, 32'h000a_0000};
		send_matrix(a);
		a[3] = a[0]; a[4] = a[1]; a[5] = a[2];
		send_matrix(a);
		a = '{MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, MAXV, MINV};
		send_matrix(a);
	endtask

	task automatic test_random(int count);
		mat_t a;
		int kind, r, s;
		for (int n = 0; n < count; n++) begin
			if (n % 150 == 0)
				full_rate = ($urandom_range(0, 2) == 0);
			kind = $urandom_range(0, 9);
			foreach (a[k]) a[k] = modest();
			if (kind == 0) begin
				foreach (a[k]) a[k] = $urandom();
			end else if (kind == 1) begin
				// Two equal rows make the matrix singular.
				r = $urandom_range(0, 2);
				s = (r + $urandom_range(1, 2)) % 3;
				for (int c = 0; c < 3; c++) a[s*3+c] = a[r*3+c];
			end else if (kind == 2) begin
				foreach (a[k]) a[k] = DW'($signed($urandom_range(0, 6)) - 3);
			end else if (kind == 3) begin
				foreach (a[k]) a[k] = ($urandom_range(0, 1)) ? $urandom() : modest();
			end
			send_matrix(a);
		end
		full_rate = 0;
	endtask

	// Result side: random stalls after each accepted inverse.
	initial begin
		int n;
		@(posedge arst_n);
		m_tready <= 1;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				n = pause_len();
				if (n > 0) begin
					m_tready <= 0;
					repeat (n) @(posedge clk);
					m_tready <= 1;
				end
			end
		end
	end

	always @(posedge clk) begin
		inverse_t exp_inv;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_inverses.size() == 0) begin
				$display("%0t: unexpected inverse %h user %b", $time, m_tdata, m_tuser);
				errors++;
			end else begin
				exp_inv = pending_inverses.pop_front();
				inverses_checked++;
				if (exp_inv.singular) singular_seen++;
				if (exp_inv.saturated) saturated_seen++;
				for (int k = 0; k < 9; k++)
					if (m_tdata[k*DW +: DW] !== exp_inv.b[k]) begin
						$display("%0t: element b%0d%0d expected %h actual %h", $time,
							k / 3, k % 3, exp_inv.b[k], m_tdata[k*DW +: DW]);
						errors++;
					end
				if (m_tuser[mi3_pkg::USER_SINGULAR] !== exp_inv.singular) begin
					$display("%0t: singular expected %b actual %b", $time,
						exp_inv.singular, m_tuser[mi3_pkg::USER_SINGULAR]);
					errors++;
				end
				if (m_tuser[mi3_pkg::USER_SATURATED] !== exp_inv.saturated) begin
					$display("%0t: saturated expected %b actual %b", $time,
						exp_inv.saturated, m_tuser[mi3_pkg::USER_SATURATED]);
					errors++;
				end
			end
		end
	end

	initial begin
		#20ms;
		$display("matrix_inverse_3x3: mismatch");
		$finish;
	end

	initial begin
		int waited;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_random(1330);
		s_tvalid <= 0;
		waited = 0;
		while (pending_inverses.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (60) @(posedge clk);
		$display("Sent %0d matrices, checked %0d inverses.", matrices_sent, inverses_checked);
		$display("Of those %0d were singular and %0d saturated.", singular_seen,
			saturated_seen);
		if (errors == 0 && pending_inverses.size() == 0)
			$display("matrix_inverse_3x3: match");
		else
			$display("matrix_inverse_3x3: mismatch");
		$finish;
	end

endmodule

// File: files.f
rtl/mi3_pkg.sv
rtl/mi3_cof.sv
rtl/mi3_det.sv
rtl/mi3_div.sv
rtl/matrix_inverse_3x3.sv
tb/matrix_inverse_3x3_tb.sv
